// File: hw/rtl/ils_pkg.sv
// Shared types, constants and helpers for the indexed list store.
// No dependencies; every other file of the block imports this package.
package ils_pkg;

    localparam int DEPTH_DEF = 64;   // default and largest store depth
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 7;    // holds 0..64
    localparam int ADDR_W    = 6;    // widest entry address, also found_index width

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_DEL_IDX = 3'd1,
        CMD_DEL_VAL = 3'd2,
        CMD_SWAP    = 3'd3,
        CMD_READ    = 3'd4,
        CMD_FIND    = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        cmd_code_t          cmd;
        logic [CNT_W-1:0]   position;
        logic [ADDR_W-1:0]  second_position;
        logic signed [DATA_W-1:0] operand_value;
    } ils_req_t;

    typedef struct packed {
        status_t            status;
        logic signed [DATA_W-1:0] read_value;
        logic [ADDR_W-1:0]  found_index;
        logic [CNT_W-1:0]   entry_count;
        logic [CNT_W-1:0]   removed_count;
        logic               last;
    } ils_res_t;

    // One read and one write port, addresses sized for the deepest store
    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [DATA_W-1:0]  wr_data;
    } mem_req_t;

    function automatic ils_res_t make_result(
        input status_t           st,
        input logic [DATA_W-1:0] rv,
        input logic [ADDR_W-1:0] fi,
        input logic [CNT_W-1:0]  cnt,
        input logic [CNT_W-1:0]  rm,
        input logic              lst
    );
        ils_res_t r;
        r.status        = st;
        r.read_value    = $signed(rv);
        r.found_index   = fi;
        r.entry_count   = cnt;
        r.removed_count = rm;
        r.last          = lst;
        return r;
    endfunction

endpackage

// File: hw/rtl/ils_mem.sv
// Entry memory of the indexed list store: one write port, one registered read port.
// Depends on ils_pkg (mem_req_t, DATA_W).
module ils_mem
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ils_ctrl.sv
// Command sequencer of the indexed list store: walks the entry memory,
// moves entries and builds result transfers. Depends on ils_pkg.
module ils_ctrl
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ils_req_t          request,
    output logic              busy,
    output logic              result_valid,
    output ils_res_t          result,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] rdata
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,   // issue one read per cycle from rp toward lim
        S_TAIL,   // last read data arrives
        S_FIN,    // final write / final result
        S_SWA,
        S_SWB,
        S_SWW1,
        S_SWW2
    } state_t;

    state_t             state_reg;
    cmd_code_t          cmd_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]  pos2_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   rp_reg;
    logic [CNT_W-1:0]   lim_reg;
    logic [CNT_W-1:0]   wp_reg;
    logic               dv_reg;
    logic [CNT_W-1:0]   di_reg;
    logic               hit_vld_reg;
    logic [ADDR_W-1:0]  hit_idx_reg;
    logic [DATA_W-1:0]  tmp_reg;
    logic               res_vld_reg;
    ils_res_t           res_reg;

    logic               match;
    logic [CNT_W-1:0]   ins_pos;
    logic [CNT_W-1:0]   di_up;
    logic [CNT_W-1:0]   di_dn;
    logic [CNT_W-1:0]   pos2_ext;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    assign match    = (rdata == val_reg);
    assign ins_pos  = (request.position > count_reg) ? count_reg : request.position;
    assign di_up    = di_reg + ONE_C;
    assign di_dn    = di_reg - ONE_C;
    assign pos2_ext = {1'b0, request.second_position};

    // memory port: reads come from the sequencer state, scan writes come in the cycle after their reads
    always_comb
    begin
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = rp_reg[ADDR_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = di_reg[ADDR_W-1:0];
        mem_req.wr_data = rdata;
        unique case (state_reg)
            S_SCAN:
            begin
                mem_req.rd_en = 1'b1;
            end
            S_SWA:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos_reg[ADDR_W-1:0];
            end
            S_SWB:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos2_reg;
            end
            S_SWW1:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg[ADDR_W-1:0];
            end
            S_SWW2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos2_reg;
                mem_req.wr_data = tmp_reg;
            end
            S_FIN:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg[ADDR_W-1:0];
                    mem_req.wr_data = val_reg;
                end
            end
            default:
            begin
            end
        endcase
        // data from a scan read (only in S_SCAN / S_TAIL, which never write otherwise)
        if (dv_reg)
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = di_up[ADDR_W-1:0];
                end
                CMD_DEL_IDX:
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = di_dn[ADDR_W-1:0];
                end
                CMD_DEL_VAL:
                begin
                    mem_req.wr_en   = !match;
                    mem_req.wr_addr = wp_reg[ADDR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= CMD_CLEAR;
            val_reg     <= '0;
            pos_reg     <= '0;
            pos2_reg    <= '0;
            count_reg   <= '0;
            rp_reg      <= '0;
            lim_reg     <= '0;
            wp_reg      <= '0;
            dv_reg      <= 1'b0;
            di_reg      <= '0;
            hit_vld_reg <= 1'b0;
            hit_idx_reg <= '0;
            tmp_reg     <= '0;
            res_vld_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            res_vld_reg <= 1'b0;
            dv_reg      <= (state_reg == S_SCAN);
            di_reg      <= rp_reg;

            if (dv_reg)
            begin
                unique case (cmd_reg)
                    CMD_DEL_VAL:
                    begin
                        if (!match)
                        begin
                            wp_reg <= wp_reg + ONE_C;
                        end
                    end
                    CMD_FIND:
                    begin
                        // hold each match back until the next one proves it is not the last
                        if (match)
                        begin
                            if (hit_vld_reg)
                            begin
                                res_vld_reg <= 1'b1;
                                res_reg <= make_result(ST_OK, '0, hit_idx_reg, count_reg,
                                                       '0, 1'b0);
                            end
                            hit_vld_reg <= 1'b1;
                            hit_idx_reg <= di_reg[ADDR_W-1:0];
                        end
                    end
                    CMD_READ:
                    begin
                        tmp_reg <= rdata;
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg     <= request.cmd;
                        val_reg     <= request.operand_value;
                        pos2_reg    <= request.second_position;
                        pos_reg     <= request.position;
                        wp_reg      <= '0;
                        hit_vld_reg <= 1'b0;
                        unique case (request.cmd)
                            CMD_INSERT:
                            begin
                                if (count_reg >= DEPTH_C)
                                begin
                                    res_vld_reg <= 1'b1;
                                    res_reg <= make_result(ST_FULL, '0, '0, count_reg, '0, 1'b1);
                                end
                                else
                                begin
                                    pos_reg <= ins_pos;
                                    rp_reg  <= count_reg - ONE_C;
                                    lim_reg <= ins_pos;
                                    state_reg <= (count_reg > ins_pos) ? S_SCAN : S_FIN;
                                end
                            end
                            CMD_DEL_IDX:
                            begin
                                if (request.position >= count_reg)
                                begin
                                    res_vld_reg <= 1'b1;
                                    res_reg <= make_result(ST_RANGE, '0, '0, count_reg, '0, 1'b1);
                                end
                                else
                                begin
                                    rp_reg  <= request.position + ONE_C;
                                    lim_reg <= count_reg - ONE_C;
                                    state_reg <= ((request.position + ONE_C) < count_reg) ?
                                                 S_SCAN : S_FIN;
                                end
                            end
                            CMD_DEL_VAL, CMD_FIND:
                            begin
                                rp_reg  <= '0;
                                lim_reg <= count_reg - ONE_C;
                                state_reg <= (count_reg != '0) ? S_SCAN : S_FIN;
                            end
                            CMD_SWAP:
                            begin
                                if ((request.position >= count_reg) || (pos2_ext >= count_reg))
                                begin
                                    res_vld_reg <= 1'b1;
                                    res_reg <= make_result(ST_RANGE, '0, '0, count_reg, '0, 1'b1);
                                end
                                else
                                begin
                                    state_reg <= S_SWA;
                                end
                            end
                            CMD_READ:
                            begin
                                if (request.position >= count_reg)
                                begin
                                    res_vld_reg <= 1'b1;
                                    res_reg <= make_result(ST_RANGE, '0, '0, count_reg, '0, 1'b1);
                                end
                                else
                                begin
                                    rp_reg    <= request.position;
                                    lim_reg   <= request.position;
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                count_reg   <= '0;
                                res_vld_reg <= 1'b1;
                                res_reg <= make_result(ST_OK, '0, '0, '0, '0, 1'b1);
                            end
                            default:
                            begin
                                res_vld_reg <= 1'b1;
                                res_reg <= make_result(ST_OK, '0, '0, count_reg, '0, 1'b1);
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (rp_reg == lim_reg)
                    begin
                        state_reg <= S_TAIL;
                    end
                    else if (cmd_reg == CMD_INSERT)
                    begin
                        rp_reg <= rp_reg - ONE_C;
                    end
                    else
                    begin
                        rp_reg <= rp_reg + ONE_C;
                    end
                end
                S_TAIL:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg   <= S_IDLE;
                    res_vld_reg <= 1'b1;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            count_reg <= count_reg + ONE_C;
                            res_reg <= make_result(ST_OK, '0, '0, count_reg + ONE_C, '0, 1'b1);
                        end
                        CMD_DEL_IDX:
                        begin
                            count_reg <= count_reg - ONE_C;
                            res_reg <= make_result(ST_OK, '0, '0, count_reg - ONE_C, '0, 1'b1);
                        end
                        CMD_DEL_VAL:
                        begin
                            count_reg <= wp_reg;
                            res_reg <= make_result((wp_reg == count_reg) ? ST_NOTFOUND : ST_OK,
                                                   '0, '0, wp_reg, count_reg - wp_reg, 1'b1);
                        end
                        CMD_FIND:
                        begin
                            if (hit_vld_reg)
                            begin
                                res_reg <= make_result(ST_OK, '0, hit_idx_reg, count_reg,
                                                       '0, 1'b1);
                            end
                            else
                            begin
                                res_reg <= make_result(ST_NOTFOUND, '0, '0, count_reg, '0, 1'b1);
                            end
                        end
                        CMD_READ:
                        begin
                            res_reg <= make_result(ST_OK, tmp_reg, '0, count_reg, '0, 1'b1);
                        end
                        default:
                        begin
                            res_reg <= make_result(ST_OK, '0, '0, count_reg, '0, 1'b1);
                        end
                    endcase
                end
                S_SWA:
                begin
                    state_reg <= S_SWB;
                end
                S_SWB:
                begin
                    tmp_reg   <= rdata;   // entry at the first index
                    state_reg <= S_SWW1;
                end
                S_SWW1:
                begin
                    state_reg <= S_SWW2;
                end
                S_SWW2:
                begin
                    state_reg   <= S_IDLE;
                    res_vld_reg <= 1'b1;
                    res_reg <= make_result(ST_OK, '0, '0, count_reg, '0, 1'b1);
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/indexed_list_store_top.sv
// Indexed list store, top level: command sequencer plus entry memory.
// Depends on ils_pkg, ils_ctrl and ils_mem.
// Usage
//   A command transfer is taken at a rising edge with start high and busy low;
//   request carries cmd, position, second_position and operand_value.
//   Results leave on result, each marked by result_valid for exactly one cycle;
//   the receiver cannot hold them off. result.last marks the final result of a
//   command. Find gives one result per matching index, in ascending order.
// Sequence (command transfer to final result)
//   Refused commands (full store, index out of range), clear and unused codes:
//   answered from idle, busy stays low. Read: S_SCAN, S_TAIL, S_FIN. Swap:
//   two reads, then two writes. Insert walks the entries from the top down to
//   position, delete by index those above position, delete by value and find
//   all entries; with nothing to move or scan the walk is skipped and the
//   answer comes from S_FIN. Walks do one read and one write per cycle; writes
//   trail the registered reads toward addresses already read, so no forwarding.
// Throughput
//   One command at a time; a new command may follow in the cycle busy drops.
// Reset
//   rst_n clears the entry count and the sequencer; the memory keeps no reset
//   and entries at or beyond the count are never read.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ils_req_t request,
    output logic     busy,
    output logic     result_valid,
    output ils_res_t result
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    ils_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .mem_req      (mem_req),
        .rdata        (mem_rdata)
    );

    ils_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

// File: hw/rtl/ils_checker.sv
// Port-level checks for the indexed list store, bound onto the top level.
// Depends on ils_pkg and indexed_list_store_top.
module ils_checker
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     busy,
    input logic     result_valid,
    input ils_res_t result
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // any error or not-found status ends its command
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |-> result.last)
        else $error("non-ok result without last");

    // a find result that is not the last leaves the block busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("partial result while idle");

    // a multi-cycle command ends with its last result as busy drops
    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && result.last)
        else $error("busy dropped without final result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.entry_count <= DEPTH_C)
                      && (result.removed_count <= DEPTH_C))
        else $error("count beyond depth");

    // removing entries is always a success
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.removed_count != '0) |-> (result.status == ST_OK))
        else $error("removed entries with error status");

endmodule

bind indexed_list_store_top ils_checker #(
    .DEPTH(DEPTH)
) u_ils_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
